/* hw/rtl/chunk_extension_validator_top_defines.svh */
// Assertion macros shared by the chunk extension validator RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef CHUNK_EXTENSION_VALIDATOR_TOP_DEFINES_SVH
`define CHUNK_EXTENSION_VALIDATOR_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define CEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define CEV_ASSERT_NEVER(lbl, expr, msg) \
  `CEV_ASSERT(lbl, !(expr), msg)

`endif

/* hw/rtl/cev_pkg.sv */
// Package for the chunk extension validator: item type, parse phases,
// character classes and the phase transition function. No dependencies.
`default_nettype none

package cev_pkg;

  localparam int unsigned DataW = 8;

  localparam logic [DataW-1:0] ChrSpace  = 8'h20;
  localparam logic [DataW-1:0] ChrTab    = 8'h09;
  localparam logic [DataW-1:0] ChrEqual  = 8'h3D;
  localparam logic [DataW-1:0] ChrQuote  = 8'h22;
  localparam logic [DataW-1:0] ChrBslash = 8'h5C;
  localparam logic [DataW-1:0] CtlLimit  = 8'h20;
  localparam logic [DataW-1:0] ChrDelete = 8'h7F;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_NAME   = 4'd1,
    PH_NAMEWS = 4'd2,
    PH_EQWS   = 4'd3,
    PH_TVAL   = 4'd4,
    PH_QSTR   = 4'd5,
    PH_QESC   = 4'd6,
    PH_TAIL   = 4'd7,
    PH_FAIL   = 4'd8
  } phase_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             byte_present;
    logic             last;
  } item_t;

  function automatic logic is_ws(input logic [DataW-1:0] c);
    return (c == ChrSpace) || (c == ChrTab);
  endfunction

  function automatic logic is_tok(input logic [DataW-1:0] c);
    logic alnum;
    logic punct;
    alnum = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h61) && (c <= 8'h7A));
    punct = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
            (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
            (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
            (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
    return alnum || punct;
  endfunction

  function automatic logic is_bad_ctl(input logic [DataW-1:0] c);
    return (c != ChrTab) && ((c < CtlLimit) || (c == ChrDelete));
  endfunction

  function automatic phase_e advance(input phase_e ph, input logic [DataW-1:0] c);
    phase_e nxt;
    nxt = PH_FAIL;
    unique case (ph)
      PH_LEAD: begin
        if (is_ws(c)) nxt = PH_LEAD;
        else if (is_tok(c)) nxt = PH_NAME;
      end
      PH_NAME: begin
        if (is_tok(c)) nxt = PH_NAME;
        else if (is_ws(c)) nxt = PH_NAMEWS;
        else if (c == ChrEqual) nxt = PH_EQWS;
      end
      PH_NAMEWS: begin
        if (is_ws(c)) nxt = PH_NAMEWS;
        else if (c == ChrEqual) nxt = PH_EQWS;
      end
      PH_EQWS: begin
        if (is_ws(c)) nxt = PH_EQWS;
        else if (c == ChrQuote) nxt = PH_QSTR;
        else if (is_tok(c)) nxt = PH_TVAL;
      end
      PH_TVAL: begin
        if (is_tok(c)) nxt = PH_TVAL;
        else if (is_ws(c)) nxt = PH_TAIL;
      end
      PH_QSTR: begin
        if (c == ChrQuote) nxt = PH_TAIL;
        else if (c == ChrBslash) nxt = PH_QESC;
        else if (!is_bad_ctl(c)) nxt = PH_QSTR;
      end
      PH_QESC: begin
        if (!is_bad_ctl(c)) nxt = PH_QSTR;
      end
      PH_TAIL: begin
        if (is_ws(c)) nxt = PH_TAIL;
      end
      default: nxt = PH_FAIL;
    endcase
    return nxt;
  endfunction

  function automatic logic phase_accepts(input phase_e ph);
    return (ph == PH_NAME) || (ph == PH_NAMEWS) || (ph == PH_TVAL) || (ph == PH_TAIL);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cev_in_reg.sv */
// Input register stage of the chunk extension validator.
// Depends on cev_pkg for the item type.
`default_nettype none

module cev_in_reg import cev_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_valid_i,
  output logic       s_ready_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/cev_phase_fsm.sv */
// Parse phase state machine of the chunk extension validator.
// Depends on cev_pkg for phases and the transition function.
`include "chunk_extension_validator_top_defines.svh"
`default_nettype none

module cev_phase_fsm import cev_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output logic       accepted_o
);

  phase_e phase_q, phase_d;
  phase_e phase_nxt;

  always_comb begin
    phase_nxt = phase_q;
    if (item_i.byte_present) begin
      phase_nxt = advance(phase_q, item_i.data_byte);
    end
    accepted_o = phase_accepts(phase_nxt);
    phase_d    = phase_q;
    if (fire_i) begin
      phase_d = item_i.last ? PH_LEAD : phase_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
    end else begin
      phase_q <= phase_d;
    end
  end

  `CEV_ASSERT(a_last_restarts, fire_i && item_i.last |=> phase_q == PH_LEAD,
              "phase did not return to leading whitespace after last byte")
  `CEV_ASSERT(a_empty_holds,
              fire_i && !item_i.byte_present && !item_i.last |=> phase_q == $past(phase_q),
              "phase changed on an item without a byte")

endmodule

`default_nettype wire

/* hw/rtl/cev_out_reg.sv */
// Result register of the chunk extension validator.
// Depends on cev_pkg for the data width.
`default_nettype none

module cev_out_reg import cev_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             accepted_i,
  output logic                  can_load_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic [DataW-1:0]      m_tdata_o
);

  logic valid_q, valid_d;
  logic accepted_q;

  assign can_load_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      accepted_q <= accepted_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {{(DataW-1){1'b0}}, accepted_q};

endmodule

`default_nettype wire

/* hw/rtl/chunk_extension_validator_top.sv */
// Flow: a transaction is captured in the input register and parsed from there by the phase
// state machine; the result of a last byte is loaded into the output register, which offers
// it on the result channel. Throughput: one byte per cycle unless a last byte stalls; the
// phase register updates as the input register drains. A result waits in the output
// register while new bytes keep flowing; only a last byte stalls behind it.
// Reset: asynchronous, clears both valid flags and sets the leading whitespace phase.
`include "chunk_extension_validator_top_defines.svh"
`default_nettype none

module chunk_extension_validator_top import cev_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [DataW-1:0] s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic             s_axis_tuser_i,  // [0] byte_present
  input  wire logic             s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [DataW-1:0]      m_axis_tdata_o   // [0] accepted, [7:1] zero
);

  item_t in_item;
  item_t item_q;
  logic  item_valid;
  logic  in_fire;
  logic  out_load;
  logic  out_can_load;
  logic  accepted;

  assign in_item = '{data_byte: s_axis_tdata_i, byte_present: s_axis_tuser_i,
                     last: s_axis_tlast_i};

  assign in_fire  = item_valid && (!item_q.last || out_can_load);
  assign out_load = in_fire && item_q.last;

  cev_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (in_fire),
    .valid_o   (item_valid),
    .item_o    (item_q)
  );

  cev_phase_fsm u_phase_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .item_i     (item_q),
    .accepted_o (accepted)
  );

  cev_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .accepted_i (accepted),
    .can_load_o (out_can_load),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

  `CEV_ASSERT_NEVER(a_no_overwrite, out_load && m_axis_tvalid_o && !m_axis_tready_i,
                    "result overwritten before it was taken")
  `CEV_ASSERT(a_result_from_last, out_load |-> item_valid && item_q.last,
              "result loaded without a last byte in the input register")

endmodule

`default_nettype wire

/* tb/chunk_extension_checker.sv */
`timescale 1ns / 1ps
// Checker for the chunk extension validator: watches both stream channels, predicts
// the accept/reject verdict of each extension string and compares it with the block's output.
// Depends on cev_pkg for the phase codes and character constants.

module chunk_extension_checker import cev_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tready_i,
  input  wire logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic       s_axis_tuser_i,  // [0] byte_present
  input  wire logic       s_axis_tlast_i,
  input  wire logic       m_axis_tvalid_i,
  input  wire logic       m_axis_tready_i,
  input  wire logic [7:0] m_axis_tdata_i,  // [0] accepted, [7:1] zero
  output int              mismatches_o,
  output int              pending_o
);

  phase_e ext_phase;
  bit     verdicts_q[$];
  int     mismatches;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == ChrSpace) || (c == ChrTab);
  endfunction

  function automatic bit is_token_byte(input logic [7:0] c);
    if ((c >= 8'h30) && (c <= 8'h39)) return 1'b1;
    if ((c >= 8'h41) && (c <= 8'h5A)) return 1'b1;
    if ((c >= 8'h61) && (c <= 8'h7A)) return 1'b1;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_forbidden_ctl(input logic [7:0] c);
    return (c != ChrTab) && ((c < 8'h20) || (c == ChrDelete));
  endfunction

  function automatic phase_e predict_phase(input phase_e ph, input logic [7:0] c);
    case (ph)
      PH_LEAD: begin
        if (is_blank(c)) return PH_LEAD;
        return is_token_byte(c) ? PH_NAME : PH_FAIL;
      end
      PH_NAME: begin
        if (is_token_byte(c)) return PH_NAME;
        if (is_blank(c)) return PH_NAMEWS;
        return (c == ChrEqual) ? PH_EQWS : PH_FAIL;
      end
      PH_NAMEWS: begin
        if (is_blank(c)) return PH_NAMEWS;
        return (c == ChrEqual) ? PH_EQWS : PH_FAIL;
      end
      PH_EQWS: begin
        if (is_blank(c)) return PH_EQWS;
        if (c == ChrQuote) return PH_QSTR;
        return is_token_byte(c) ? PH_TVAL : PH_FAIL;
      end
      PH_TVAL: begin
        if (is_token_byte(c)) return PH_TVAL;
        return is_blank(c) ? PH_TAIL : PH_FAIL;
      end
      PH_QSTR: begin
        if (c == ChrQuote) return PH_TAIL;
        if (c == ChrBslash) return PH_QESC;
        return is_forbidden_ctl(c) ? PH_FAIL : PH_QSTR;
      end
      PH_QESC: begin
        return is_forbidden_ctl(c) ? PH_FAIL : PH_QSTR;
      end
      PH_TAIL: begin
        return is_blank(c) ? PH_TAIL : PH_FAIL;
      end
      default: return PH_FAIL;
    endcase
  endfunction

  function automatic bit phase_is_complete(input phase_e ph);
    return (ph == PH_NAME) || (ph == PH_NAMEWS) || (ph == PH_TVAL) || (ph == PH_TAIL);
  endfunction

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, exp_v, act_v);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      ext_phase = PH_LEAD;
      verdicts_q.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (verdicts_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result transaction, tdata %0h", $realtime,
                     m_axis_tdata_i);
          end
          mismatches++;
        end else begin
          want = verdicts_q.pop_front();
          if (m_axis_tdata_i[0] !== want) begin
            note_mismatch("accepted", int'(want), int'(m_axis_tdata_i[0]));
          end
          if (m_axis_tdata_i[7:1] !== 7'd0) begin
            note_mismatch("tdata padding", 0, int'(m_axis_tdata_i[7:1]));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) begin
          ext_phase = predict_phase(ext_phase, s_axis_tdata_i);
        end
        if (s_axis_tlast_i) begin
          verdicts_q.push_back(phase_is_complete(ext_phase));
          ext_phase = PH_LEAD;
        end
      end
      mismatches_o <= mismatches;
      pending_o <= verdicts_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for chunk_extension_validator_top: clock, reset, extension string
// stimulus with bursty sender and stalling receiver, watchdog and verdict.
// Depends on cev_pkg, the block and chunk_extension_checker.

module tb_top;
  import cev_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 600;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'd0;  // [7:0] data_byte
  logic       s_axis_tuser_i = 1'b0;  // [0] byte_present
  logic       s_axis_tlast_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;         // [0] accepted, [7:1] zero

  int         mismatches;
  int         pending;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         items_sent = 0;
  int         ready_run = 0;
  bit         ready_phase = 1'b0;
  logic [7:0] ext_bytes[$];

  chunk_extension_validator_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  chunk_extension_checker checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i  (m_axis_tdata_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_phase = !ready_phase;
      if (ready_phase) begin
        ready_run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      end else begin
        ready_run = $urandom_range(1, 12);
      end
    end else begin
      ready_run--;
    end
    m_axis_tready_i <= ready_phase;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic present, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= ch;
    s_axis_tuser_i <= present;
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_text(input string s, input bit with_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, with_last && (i == s.len() - 1));
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? ChrSpace : ChrTab;
  endfunction

  function automatic logic [7:0] rand_token();
    int r;
    r = $urandom_range(0, 76);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    if (r < 62) return 8'(8'h61 + r - 36);
    case (r)
      62: return 8'h21;
      63: return 8'h23;
      64: return 8'h24;
      65: return 8'h25;
      66: return 8'h26;
      67: return 8'h27;
      68: return 8'h2A;
      69: return 8'h2B;
      70: return 8'h2D;
      71: return 8'h2E;
      72: return 8'h5E;
      73: return 8'h5F;
      74: return 8'h60;
      75: return 8'h7C;
      default: return 8'h7E;
    endcase
  endfunction

  task automatic push_quoted_byte();
    int         r;
    logic [7:0] ch;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      ext_bytes.push_back(ChrBslash);
      ext_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (r == 1) begin
      ext_bytes.push_back(ChrTab);
    end else if (r == 2) begin
      ext_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
    end else begin
      ch = 8'($urandom_range(8'h20, 8'h7E));
      if ((ch == ChrQuote) || (ch == ChrBslash)) ch = 8'h61;
      ext_bytes.push_back(ch);
    end
  endtask

  task automatic make_extension();
    int kind;
    ext_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 6)) ext_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) ext_bytes.push_back(rand_blank());
      repeat ($urandom_range(1, 4)) ext_bytes.push_back(rand_token());
      repeat ($urandom_range(0, 1)) ext_bytes.push_back(rand_blank());
      if ($urandom_range(0, 3) != 0) begin
        ext_bytes.push_back(ChrEqual);
        repeat ($urandom_range(0, 1)) ext_bytes.push_back(rand_blank());
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 4)) ext_bytes.push_back(rand_token());
        end else begin
          ext_bytes.push_back(ChrQuote);
          repeat ($urandom_range(0, 5)) push_quoted_byte();
          if ($urandom_range(0, 7) != 0) ext_bytes.push_back(ChrQuote);
        end
      end
      repeat ($urandom_range(0, 2)) ext_bytes.push_back(rand_blank());
      if (kind == 1) begin
        ext_bytes[$urandom_range(0, ext_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if ((kind == 2) && (ext_bytes.size() > 1)) begin
        repeat ($urandom_range(1, ext_bytes.size() - 1)) void'(ext_bytes.pop_back());
      end
    end
  endtask

  task automatic send_extension();
    int i;
    bit marker_end;
    marker_end = (ext_bytes.size() == 0) || ($urandom_range(0, 7) == 0);
    for (i = 0; i < ext_bytes.size(); i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        items_sent++;
      end
      send_item(ext_bytes[i], 1'b1, !marker_end && (i == ext_bytes.size() - 1));
      items_sent++;
    end
    if (marker_end) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'h00, 1'b0, 1'b1);
    send_text("a", 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_text("x=\"\\q\"", 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_text(" b = v\t", 1'b1);
    drain_results();

    while (items_sent < RandomItems) begin
      make_extension();
      send_extension();
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cev_pkg.sv
hw/rtl/cev_in_reg.sv
hw/rtl/cev_phase_fsm.sv
hw/rtl/cev_out_reg.sv
hw/rtl/chunk_extension_validator_top.sv
tb/chunk_extension_checker.sv
tb/tb_top.sv
